### src/checksummed_register_frame_master_top_macros.svh
// assertion macros shared by the frame master modules
`ifndef CHECKSUMMED_REGISTER_FRAME_MASTER_TOP_MACROS_SVH
`define CHECKSUMMED_REGISTER_FRAME_MASTER_TOP_MACROS_SVH

// same-cycle implication
`define CRFM_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("crfm same-cycle check failed");

// next-cycle implication
`define CRFM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("crfm next-cycle check failed");

`endif

### src/crfm_pkg.sv
// ----------------------------------------------------------------------------
// crfm_pkg
// Types, codes and constants of the checksummed register frame master.
// ----------------------------------------------------------------------------
package crfm_pkg;

  localparam int MAX_DATA_BYTES = 4;
  localparam logic [2:0] COUNT_LIMIT = (MAX_DATA_BYTES > 4) ? 3'd4 : 3'(MAX_DATA_BYTES);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  localparam logic [1:0] JOB_REJECT    = 2'd0;
  localparam logic [1:0] JOB_WRITE     = 2'd1;
  localparam logic [1:0] JOB_READ_HDR  = 2'd2;
  localparam logic [1:0] JOB_READ_DONE = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] address;
    logic [2:0]  byte_count;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        frame_last;
    logic        read_done;
    logic [31:0] read_data;
    logic        checksum_ok;
    logic        request_rejected;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lo;
    logic [7:0]  cmd;
    logic [2:0]  cnt;
    logic [31:0] data;
    logic        ok;
  } job_t;

  typedef struct packed {
    logic full;
  } queue_ctl_t;

endpackage

### src/crfm_front.sv
// ----------------------------------------------------------------------------
// crfm_front
// Accepts requests and received bytes, keeps the read state, queues jobs.
// ----------------------------------------------------------------------------
module crfm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crfm_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output crfm_pkg::job_t     q_job
);

  logic        read_active_r, read_active_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [31:0] data_accum_r, data_accum_nxt;

  logic       accept;
  logic       is_req;
  logic       cnt_bad;
  logic [7:0] lo;
  logic [7:0] cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_req   = (in_data.op == crfm_pkg::OP_WRITE) || (in_data.op == crfm_pkg::OP_READ);
  assign cnt_bad  = (in_data.byte_count == 3'd0) ||
                    (in_data.byte_count > crfm_pkg::COUNT_LIMIT);
  assign lo       = in_data.address[7:0];
  assign cmd      = {in_data.op == crfm_pkg::OP_WRITE, in_data.address[10:8], 4'b0000};

  always_comb begin
    read_active_nxt = read_active_r;
    bytes_left_nxt  = bytes_left_r;
    running_sum_nxt = running_sum_r;
    data_accum_nxt  = data_accum_r;
    q_push          = 1'b0;
    q_job           = '0;
    q_job.lo        = lo;
    q_job.cmd       = cmd;
    q_job.cnt       = in_data.byte_count;
    if (accept) begin
      if (is_req) begin
        q_push = 1'b1;
        if (read_active_r || cnt_bad) begin
          q_job.kind = crfm_pkg::JOB_REJECT;
        end else if (in_data.op == crfm_pkg::OP_WRITE) begin
          q_job.kind = crfm_pkg::JOB_WRITE;
          q_job.data = in_data.write_data;
        end else begin
          q_job.kind      = crfm_pkg::JOB_READ_HDR;
          read_active_nxt = 1'b1;
          bytes_left_nxt  = in_data.byte_count;
          running_sum_nxt = lo + cmd;
          data_accum_nxt  = '0;
        end
      end else if ((in_data.op == crfm_pkg::OP_RX) && read_active_r) begin
        if (bytes_left_r != 3'd0) begin
          data_accum_nxt  = {data_accum_r[23:0], in_data.rx_byte};
          running_sum_nxt = running_sum_r + in_data.rx_byte;
          bytes_left_nxt  = bytes_left_r - 3'd1;
        end else begin
          q_push          = 1'b1;
          q_job.kind      = crfm_pkg::JOB_READ_DONE;
          q_job.data      = data_accum_r;
          q_job.ok        = (in_data.rx_byte == ~running_sum_r);
          read_active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_active_r <= 1'b0;
      bytes_left_r  <= '0;
      running_sum_r <= '0;
      data_accum_r  <= '0;
    end else begin
      read_active_r <= read_active_nxt;
      bytes_left_r  <= bytes_left_nxt;
      running_sum_r <= running_sum_nxt;
      data_accum_r  <= data_accum_nxt;
    end
  end

endmodule

### src/crfm_queue.sv
// ----------------------------------------------------------------------------
// crfm_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "checksummed_register_frame_master_top_macros.svh"

module crfm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  crfm_pkg::job_t       job_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output crfm_pkg::job_t       job_o,
  output crfm_pkg::queue_ctl_t ctl_o
);

  crfm_pkg::job_t                     mem_r [crfm_pkg::QUEUE_DEPTH];
  logic [crfm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [crfm_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [crfm_pkg::QUEUE_CNT_W-1:0]   count_r, count_nxt;
  logic                               full;
  logic                               do_pop;

  localparam logic [crfm_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    crfm_pkg::QUEUE_PTR_W'(crfm_pkg::QUEUE_DEPTH - 1);

  assign full      = (count_r == crfm_pkg::QUEUE_CNT_W'(crfm_pkg::QUEUE_DEPTH));
  assign valid_o   = (count_r != '0);
  assign job_o     = mem_r[rd_ptr_r];
  assign do_pop    = pop_i && valid_o;
  assign ctl_o.full = full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_i && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CRFM_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push_i, !full)

endmodule

### src/crfm_back.sv
// ----------------------------------------------------------------------------
// crfm_back
// Expands queued jobs into frame bytes and status results, one per cycle while busy and not stalled.
// ----------------------------------------------------------------------------
`include "checksummed_register_frame_master_top_macros.svh"

module crfm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  crfm_pkg::job_t      q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output crfm_pkg::out_item_t out_data
);

  logic                busy_r, busy_nxt;
  crfm_pkg::job_t      job_r, job_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  crfm_pkg::out_item_t out_data_r, out_data_nxt;

  logic                slot_free;
  logic                emit;
  crfm_pkg::out_item_t res;
  logic [2:0]          byte_idx;
  logic [31:0]         shifted;
  logic                in_data_bytes;

  assign slot_free     = !out_valid_r || !out_stall;
  assign emit          = busy_r && slot_free;
  assign q_pop         = !busy_r && q_valid;
  assign byte_idx      = job_r.cnt + 3'd1 - idx_r;
  assign shifted       = job_r.data >> {byte_idx[1:0], 3'b000};
  assign in_data_bytes = ({1'b0, idx_r} < ({1'b0, job_r.cnt} + 4'd2));
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_comb begin
    res = '0;
    unique case (job_r.kind)
      crfm_pkg::JOB_REJECT: begin
        res.request_rejected = 1'b1;
        res.frame_last       = 1'b1;
      end
      crfm_pkg::JOB_READ_DONE: begin
        res.read_done   = 1'b1;
        res.frame_last  = 1'b1;
        res.read_data   = job_r.data;
        res.checksum_ok = job_r.ok;
      end
      crfm_pkg::JOB_READ_HDR: begin
        res.tx_valid   = 1'b1;
        res.tx_byte    = (idx_r == 3'd0) ? job_r.lo : job_r.cmd;
        res.frame_last = (idx_r != 3'd0);
      end
      default: begin
        res.tx_valid = 1'b1;
        priority if (idx_r == 3'd0) begin
          res.tx_byte = job_r.lo;
        end else if (idx_r == 3'd1) begin
          res.tx_byte = job_r.cmd;
        end else if (in_data_bytes) begin
          res.tx_byte = shifted[7:0];
        end else begin
          res.tx_byte    = ~sum_r;
          res.frame_last = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      job_nxt  = q_job;
      idx_nxt  = '0;
      sum_nxt  = '0;
    end
    if (slot_free) begin
      out_valid_nxt = emit;
      out_data_nxt  = res;
    end
    if (emit) begin
      idx_nxt = idx_r + 3'd1;
      sum_nxt = sum_r + res.tx_byte;
      if (res.frame_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    idx_r        <= idx_nxt;
    sum_r        <= sum_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CRFM_ASSERT_IMPLY(a_done_is_last, clk, rst_n, out_valid_r && out_data_r.read_done, out_data_r.frame_last && !out_data_r.tx_valid)
  `CRFM_ASSERT_IMPLY(a_idx_bound, clk, rst_n, busy_r, idx_r <= 3'd6)
  `CRFM_ASSERT_NEXT(a_last_frees, clk, rst_n, emit && res.frame_last, !busy_r)

endmodule

### src/checksummed_register_frame_master_top.sv
// an accepted item's first result passes the job queue, the back unit's job
//   register and the output register; the back unit takes one job at a time and
//   emits write: lo, cmd, data, checksum; read header: lo, cmd; other: one result
// the input takes one item per cycle while the 2-entry job queue has room
// reset: synchronous active-low rst_n clears the read state, queue and output valid
// ----------------------------------------------------------------------------
// checksummed_register_frame_master_top
// Register-access frame master: builds write frames with an inverted sum checksum
// and read header frames, and checks the inverted sum checksum of read replies.
// ----------------------------------------------------------------------------
module checksummed_register_frame_master_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crfm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crfm_pkg::out_item_t out_data
);

  logic                 q_push;
  crfm_pkg::job_t       push_job;
  logic                 q_pop;
  logic                 q_valid;
  crfm_pkg::job_t       head_job;
  crfm_pkg::queue_ctl_t q_ctl;

  crfm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_ctl.full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  crfm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (head_job),
    .ctl_o   (q_ctl)
  );

  crfm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sim/checksummed_register_frame_master_top_tb.sv
// ----------------------------------------------------------------------------
// checksummed_register_frame_master_top_tb
// Drives write, read and received-byte requests into the frame master with
// random gaps and output stalls. It predicts every frame byte, read result and
// refusal, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module checksummed_register_frame_master_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  class frame_ledger;
    bit                  read_open;
    logic [2:0]          bytes_due;
    logic [7:0]          byte_sum;
    logic [31:0]         value_so_far;
    crfm_pkg::out_item_t due_results[$];
    int                  errors;
    int                  compared;
    int                  handled;
    int                  writes;
    int                  reads;
    int                  bad_sums;
    int                  refused;

    function void push_byte(logic [7:0] b, bit last);
      crfm_pkg::out_item_t r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.frame_last = last;
      due_results.push_back(r);
    endfunction

    function void note_request(crfm_pkg::in_item_t it);
      crfm_pkg::out_item_t r;
      logic [7:0]          lo;
      logic [7:0]          cmd;
      logic [7:0]          sum;
      logic [7:0]          b;
      r = '0;
      if (it.op == crfm_pkg::OP_WRITE || it.op == crfm_pkg::OP_READ) begin
        handled++;
        if (read_open || it.byte_count == 3'd0 || it.byte_count > crfm_pkg::COUNT_LIMIT) begin
          r.frame_last = 1'b1;
          r.request_rejected = 1'b1;
          due_results.push_back(r);
          refused++;
        end else begin
          lo = it.address[7:0];
          cmd = {it.address[11:8], 4'h0};
          cmd[7] = (it.op == crfm_pkg::OP_WRITE);
          sum = lo + cmd;
          push_byte(lo, 1'b0);
          push_byte(cmd, it.op == crfm_pkg::OP_READ);
          if (it.op == crfm_pkg::OP_WRITE) begin
            for (int i = int'(it.byte_count) - 1; i >= 0; i--) begin
              b = it.write_data[8*i +: 8];
              sum = sum + b;
              push_byte(b, 1'b0);
            end
            push_byte(~sum, 1'b1);
            writes++;
          end else begin
            read_open = 1'b1;
            bytes_due = it.byte_count;
            byte_sum = sum;
            value_so_far = '0;
          end
        end
      end else if (it.op == crfm_pkg::OP_RX && read_open) begin
        handled++;
        if (bytes_due != 3'd0) begin
          value_so_far = {value_so_far[23:0], it.rx_byte};
          byte_sum = byte_sum + it.rx_byte;
          bytes_due = bytes_due - 3'd1;
        end else begin
          r.frame_last = 1'b1;
          r.read_done = 1'b1;
          r.read_data = value_so_far;
          r.checksum_ok = (it.rx_byte == ~byte_sum);
          due_results.push_back(r);
          read_open = 1'b0;
          reads++;
          if (!r.checksum_ok) bad_sums++;
        end
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(crfm_pkg::out_item_t got);
      crfm_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: %h", got);
        errors++;
      end else begin
        want = due_results.pop_front();
        compared++;
        compare_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
        compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
        compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
        compare_field("read_done", 32'(want.read_done), 32'(got.read_done));
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("checksum_ok", 32'(want.checksum_ok), 32'(got.checksum_ok));
        compare_field("request_rejected", 32'(want.request_rejected),
                      32'(got.request_rejected));
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  crfm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  crfm_pkg::out_item_t out_data;

  frame_ledger ledger = new();
  bit          no_gaps = 1'b0;
  bit          long_hold = 1'b0;
  int          held_cycles = 0;

  checksummed_register_frame_master_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_result(out_data);
    if (rst_n && in_valid && in_stall) held_cycles++;
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int hold;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        hold = 250;
        long_hold = 1'b0;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 17);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #5ms;
    $display("checksummed_register_frame_master_top_tb: done, errors");
    $finish;
  end

  function automatic crfm_pkg::in_item_t make_item(logic [1:0] op, logic [11:0] addr,
                                                   logic [2:0] cnt, logic [31:0] wdata,
                                                   logic [7:0] rx);
    crfm_pkg::in_item_t it;
    it.op = op;
    it.address = addr;
    it.byte_count = cnt;
    it.write_data = wdata;
    it.rx_byte = rx;
    return it;
  endfunction

  task automatic send_request(input crfm_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_request(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic read_frame(input logic [11:0] addr, input logic [2:0] cnt,
                            input logic [31:0] value, input bit good_sum,
                            input bit interject);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] chk;
    sum = addr[7:0] + {1'b0, addr[10:8], 4'h0};
    send_request(make_item(crfm_pkg::OP_READ, addr, cnt, $urandom, 8'($urandom)));
    if (interject) begin
      send_request(make_item(crfm_pkg::OP_WRITE, 12'($urandom), 3'd2, $urandom,
                             8'($urandom)));
      send_request(make_item(crfm_pkg::OP_READ, 12'($urandom), 3'd1, $urandom,
                             8'($urandom)));
      send_request(make_item(OP_UNUSED, 12'($urandom), 3'($urandom), $urandom,
                             8'($urandom)));
    end
    for (int i = int'(cnt) - 1; i >= 0; i--) begin
      b = value[8*i +: 8];
      sum = sum + b;
      send_request(make_item(crfm_pkg::OP_RX, 12'($urandom), 3'($urandom), $urandom, b));
    end
    if (good_sum) chk = ~sum;
    else chk = 8'($urandom);
    send_request(make_item(crfm_pkg::OP_RX, 12'($urandom), 3'($urandom), $urandom, chk));
  endtask

  task automatic random_step();
    logic [2:0] cnt;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        send_request(make_item(crfm_pkg::OP_WRITE, 12'($urandom), 3'($urandom_range(1, 4)),
                               $urandom, 8'($urandom)));
      end
      4, 5, 6: begin
        read_frame(12'($urandom), 3'($urandom_range(1, 4)), $urandom,
                   $urandom_range(0, 3) != 0, 1'b0);
      end
      7: begin
        cnt = 3'($urandom_range(0, 3));
        if (cnt != 3'd0) cnt = cnt + 3'd4;
        send_request(make_item($urandom_range(0, 1) ? crfm_pkg::OP_READ : crfm_pkg::OP_WRITE,
                               12'($urandom), cnt, $urandom, 8'($urandom)));
      end
      8: begin
        send_request(make_item($urandom_range(0, 1) ? OP_UNUSED : crfm_pkg::OP_RX,
                               12'($urandom), 3'($urandom), $urandom, 8'($urandom)));
      end
      default: begin
        read_frame(12'($urandom), 3'($urandom_range(1, 4)), $urandom,
                   $urandom_range(0, 1) != 0, 1'b1);
      end
    endcase
  endtask

  initial begin
    int base;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    send_request(make_item(crfm_pkg::OP_WRITE, 12'h000, 3'd1, 32'h0000_0000, 8'h00));
    send_request(make_item(crfm_pkg::OP_WRITE, 12'hfff, 3'd4, 32'hffff_ffff, 8'hff));
    send_request(make_item(crfm_pkg::OP_WRITE, 12'h800, 3'd2, 32'h1234_a5c3, 8'h00));
    send_request(make_item(crfm_pkg::OP_WRITE, 12'h7a5, 3'd3, 32'h00c0_ffee, 8'h00));
    read_frame(12'hfff, 3'd4, 32'hff00_a55a, 1'b1, 1'b1);
    read_frame(12'h000, 3'd1, 32'h0000_0080, 1'b0, 1'b0);
    send_request(make_item(crfm_pkg::OP_WRITE, 12'h123, 3'd0, 32'hdead_beef, 8'h00));
    send_request(make_item(crfm_pkg::OP_READ, 12'h456, 3'd5, 32'h0, 8'h00));
    send_request(make_item(crfm_pkg::OP_WRITE, 12'h789, 3'd7, 32'hffff_ffff, 8'h00));
    send_request(make_item(crfm_pkg::OP_RX, 12'h000, 3'd1, 32'h0, 8'h5a));
    send_request(make_item(OP_UNUSED, 12'hfff, 3'd7, 32'hffff_ffff, 8'hff));
    drain();

    base = ledger.handled;

    // back-to-back stretch
    no_gaps = 1'b1;
    repeat (10) random_step();
    no_gaps = 1'b0;

    // long output hold-off while requests keep coming
    long_hold = 1'b1;
    no_gaps = 1'b1;
    repeat (12) begin
      send_request(make_item(crfm_pkg::OP_WRITE, 12'($urandom), 3'd4, $urandom,
                             8'($urandom)));
    end
    no_gaps = 1'b0;
    drain();

    while (ledger.handled - base < 45) random_step();
    drain();
    while (ledger.handled - base < 90) random_step();
    drain();
    repeat (20) @(posedge clk);

    $display("frames: %0d writes, %0d reads (%0d with bad checksum), %0d refused",
             ledger.writes, ledger.reads, ledger.bad_sums, ledger.refused);
    $display("results compared: %0d, cycles with input held off: %0d",
             ledger.compared, held_cycles);
    if (ledger.errors == 0) begin
      $display("checksummed_register_frame_master_top_tb: done, clean");
    end else begin
      $display("checksummed_register_frame_master_top_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/crfm_pkg.sv
src/crfm_front.sv
src/crfm_queue.sv
src/crfm_back.sv
src/checksummed_register_frame_master_top.sv
sim/checksummed_register_frame_master_top_tb.sv
